// ----- sv/sbtr_pkg.sv -----
package sbtr_pkg;

	// ring geometry
	localparam int unsigned RING_BYTES = 4096;
	localparam int unsigned RING_AW    = $clog2(RING_BYTES);
	localparam int unsigned RING_BW    = $clog2(RING_BYTES + 1);

	// operation codes
	typedef enum logic [0:0] {
		OP_APPEND = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	// request word
	typedef struct packed {
		op_t         operation;
		logic [7:0]  data_byte;
		logic [31:0] from_seq;
	} req_word_t;

	// response word
	typedef struct packed {
		logic [7:0]  read_byte;
		logic        byte_valid;
		logic [31:0] first_seq;
		logic [31:0] total_seq;
	} rsp_word_t;

	// store write from the tracker
	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
		logic [7:0]         data;
	} wr_cmd_t;

	// clamped read request handed to the lookup stage
	typedef struct packed {
		logic               vld;
		logic               byte_valid;
		logic [31:0]        first_seq;
		logic [31:0]        total_seq;
		logic [RING_BW-1:0] back;
		logic [RING_AW-1:0] head;
	} rd_req_t;

endpackage

// ----- sv/sbtr_ram.sv -----
module sbtr_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [sbtr_pkg::RING_AW-1:0] waddr,
	input  logic [7:0]                   wdata,
	input  logic                         re,
	input  logic [sbtr_pkg::RING_AW-1:0] raddr,
	output logic [7:0]                   rdata
);

	logic [7:0] mem [sbtr_pkg::RING_BYTES];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, returns old contents on a same-cycle write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/sbtr_track.sv -----
module sbtr_track (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vld_s1,
	input  sbtr_pkg::req_word_t word_s1,
	output sbtr_pkg::wr_cmd_t   wr,
	output sbtr_pkg::rd_req_t   rd
);

	localparam logic [31:0] RingLen32 = 32'(sbtr_pkg::RING_BYTES);
	localparam logic [sbtr_pkg::RING_BW-1:0] RingLenB = sbtr_pkg::RING_BW'(sbtr_pkg::RING_BYTES);
	localparam logic [sbtr_pkg::RING_AW-1:0] HeadLast =
		sbtr_pkg::RING_AW'(sbtr_pkg::RING_BYTES - 1);

	logic [sbtr_pkg::RING_AW-1:0] head_q;
	logic [31:0]                  total_q;
	logic                         is_append;
	logic                         is_read;
	logic [sbtr_pkg::RING_BW-1:0] held;
	logic [31:0]                  oldest;
	logic [31:0]                  first;
	logic [31:0]                  back_full;

	assign is_append = vld_s1 && (word_s1.operation == sbtr_pkg::OP_APPEND);
	assign is_read   = vld_s1 && (word_s1.operation == sbtr_pkg::OP_READ);

	// head and running total advance on every append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			total_q <= '0;
		end else if (adv && is_append) begin
			head_q  <= (head_q == HeadLast) ? '0 : head_q + 1'b1;
			total_q <= total_q + 32'd1;
		end
	end

	// store write at the head
	always_comb begin
		wr.en   = adv && is_append;
		wr.addr = head_q;
		wr.data = word_s1.data_byte;
	end

	// clamp the requested sequence into [oldest held, total]
	always_comb begin
		held      = (total_q < RingLen32) ? total_q[sbtr_pkg::RING_BW-1:0] : RingLenB;
		oldest    = total_q - 32'(held);
		first     = word_s1.from_seq;
		if (first < oldest) begin
			first = oldest;
		end
		if (first > total_q) begin
			first = total_q;
		end
		back_full = total_q - first;
	end

	always_comb begin
		rd.vld        = is_read;
		rd.byte_valid = (first != total_q);
		rd.first_seq  = first;
		rd.total_seq  = total_q;
		rd.back       = back_full[sbtr_pkg::RING_BW-1:0];
		rd.head       = head_q;
	end

endmodule

// ----- sv/sequenced_byte_trace_ring_unit.sv -----
// Byte trace ring of sbtr_pkg::RING_BYTES entries with 32-bit sequence numbers.
// An append word stores its byte at the head and produces no response; a read
// word returns the requested sequence clamped to the held window, the running
// total and the byte at that sequence (zero when the clamped sequence equals
// the total). One word is accepted per cycle while req_stall is low; a read
// response passes through the input register, the clamp, the store lookup with
// the synchronous RAM read and then the output register. Requests keep
// flowing while a response waits, until the lookup stage also holds a read.
module sequenced_byte_trace_ring_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  sbtr_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output sbtr_pkg::rsp_word_t rsp
);

	localparam logic [sbtr_pkg::RING_BW:0] RingLenX = (sbtr_pkg::RING_BW + 1)'(sbtr_pkg::RING_BYTES);

	logic                         adv;
	logic                         vld_s1;
	sbtr_pkg::req_word_t          word_s1;
	sbtr_pkg::wr_cmd_t            wr;
	sbtr_pkg::rd_req_t            rd;
	sbtr_pkg::rd_req_t            rd_s2;
	logic                         vld_s3;
	logic                         byte_valid_s3;
	logic [31:0]                  first_s3;
	logic [31:0]                  total_s3;
	logic [7:0]                   rdata;
	logic [sbtr_pkg::RING_BW:0]   diff;
	logic [sbtr_pkg::RING_BW:0]   wrapped;
	logic [sbtr_pkg::RING_AW-1:0] raddr;
	logic                         rsp_vld_q;
	sbtr_pkg::rsp_word_t          rsp_q;

	// pipeline holds only when a read sits in the lookup stage behind a blocked response
	assign adv       = !(vld_s3 && rsp_vld_q && rsp_stall);
	assign req_stall = !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1 <= req;
		end
	end

	// head, total and clamping
	sbtr_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_s1  (vld_s1),
		.word_s1 (word_s1),
		.wr      (wr),
		.rd      (rd)
	);

	// clamped read request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s2 <= '0;
		end else if (adv) begin
			rd_s2 <= rd;
		end
	end

	// store index: head minus distance back, wrapped into the ring
	always_comb begin
		diff    = {2'b00, rd_s2.head} - {1'b0, rd_s2.back};
		wrapped = diff[sbtr_pkg::RING_BW] ? diff + RingLenX : diff;
		raddr   = wrapped[sbtr_pkg::RING_AW-1:0];
	end

	sbtr_ram u_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (adv && rd_s2.vld && rd_s2.byte_valid),
		.raddr (raddr),
		.rdata (rdata)
	);

	// lookup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= rd_s2.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_valid_s3 <= rd_s2.byte_valid;
			first_s3      <= rd_s2.first_seq;
			total_s3      <= rd_s2.total_seq;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv && vld_s3) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s3) begin
			rsp_q.read_byte  <= byte_valid_s3 ? rdata : 8'd0;
			rsp_q.byte_valid <= byte_valid_s3;
			rsp_q.first_seq  <= first_s3;
			rsp_q.total_seq  <= total_s3;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule
